>>> hw/rtl/lmbc_pkg.sv
// ----------------------------------------------------------------------------
// lmbc_pkg
// shared types and codes for the pixel driver with blink and crossfade modes
// ----------------------------------------------------------------------------
package lmbc_pkg;

	localparam int unsigned TICK_COUNTER_BITS_DEF = 16;
	localparam int unsigned INTERVAL_BITS = 16;
	localparam int unsigned CFG_INDEX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 16;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_SET_MODE = 2'd1;
	localparam logic [1:0] REQ_LINK_DROP = 2'd2;

	localparam logic [2:0] MODE_OFF = 3'd0;
	localparam logic [2:0] MODE_SLOW = 3'd1;
	localparam logic [2:0] MODE_FAST = 3'd2;
	localparam logic [2:0] MODE_STEADY = 3'd3;
	localparam logic [2:0] MODE_FADE = 3'd4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_RED = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_GREEN = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_BLUE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_BLINK = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_BLINK = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_STEP = 3'd5;

	localparam logic [7:0] BASE_RED_RST = 8'd255;
	localparam logic [7:0] BASE_GREEN_RST = 8'd0;
	localparam logic [7:0] BASE_BLUE_RST = 8'd0;
	localparam logic [INTERVAL_BITS-1:0] SLOW_BLINK_RST = 16'd1000;
	localparam logic [INTERVAL_BITS-1:0] FAST_BLINK_RST = 16'd500;
	localparam logic [INTERVAL_BITS-1:0] FADE_STEP_RST = 16'd10;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] new_mode;
	} req_t;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic [2:0] active_mode;
	} rsp_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t base;
		logic [INTERVAL_BITS-1:0] slow_blink_ticks;
		logic [INTERVAL_BITS-1:0] fast_blink_ticks;
		logic [INTERVAL_BITS-1:0] fade_step_ticks;
	} cfg_t;

endpackage

>>> hw/rtl/led_mode_blink_crossfade.sv
// ----------------------------------------------------------------------------
// led_mode_blink_crossfade
// single rgb pixel driver: off, slow blink, fast blink, steady and crossfade
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction per tick, set-mode request or link drop;
//   each one yields exactly one rsp transaction with the pixel color and
//   the mode in force after it
//   cfg channel: register writes (base color, blink and fade intervals),
//   always ready; user issues them only while the block is idle, not enforced
//   a request is captured in the request register, its result then in the
//   response register; throughput: one request per cycle while rsp is not
//   stalled, set by the state update between the two registers
//   a stalled rsp holds its transaction; the request register still takes
//   one more item, after which req_ready drops until rsp is taken
//   reset: mode off, counters and fade weight zero, pixel dark, registers
//   at their defaults, both pipeline registers empty
// ----------------------------------------------------------------------------
module led_mode_blink_crossfade #(
	parameter int unsigned TICK_COUNTER_BITS = lmbc_pkg::TICK_COUNTER_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  lmbc_pkg::req_t                        req,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output lmbc_pkg::rsp_t                        rsp,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lmbc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [lmbc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	logic            valid_s1;
	lmbc_pkg::req_t  item_s1;
	logic            rsp_valid_q;
	lmbc_pkg::rsp_t  rsp_q;
	lmbc_pkg::cfg_t  cfg_q;
	lmbc_pkg::rsp_t  result;
	logic            step;

	assign step = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base.red <= lmbc_pkg::BASE_RED_RST;
			cfg_q.base.green <= lmbc_pkg::BASE_GREEN_RST;
			cfg_q.base.blue <= lmbc_pkg::BASE_BLUE_RST;
			cfg_q.slow_blink_ticks <= lmbc_pkg::SLOW_BLINK_RST;
			cfg_q.fast_blink_ticks <= lmbc_pkg::FAST_BLINK_RST;
			cfg_q.fade_step_ticks <= lmbc_pkg::FADE_STEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lmbc_pkg::REG_BASE_RED: cfg_q.base.red <= cfg_data[7:0];
				lmbc_pkg::REG_BASE_GREEN: cfg_q.base.green <= cfg_data[7:0];
				lmbc_pkg::REG_BASE_BLUE: cfg_q.base.blue <= cfg_data[7:0];
				lmbc_pkg::REG_SLOW_BLINK: cfg_q.slow_blink_ticks <= cfg_data;
				lmbc_pkg::REG_FAST_BLINK: cfg_q.fast_blink_ticks <= cfg_data;
				lmbc_pkg::REG_FADE_STEP: cfg_q.fade_step_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	lmbc_core #(
		.TICK_COUNTER_BITS(TICK_COUNTER_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.cfg(cfg_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

>>> hw/rtl/lmbc_mix.sv
// ----------------------------------------------------------------------------
// lmbc_mix
// one color channel blended with its complement: (c*(255-w)+(255-c)*w)/255
// ----------------------------------------------------------------------------
module lmbc_mix (
	input  logic [7:0] chan,
	input  logic [7:0] weight,
	output logic [7:0] mixed
);

	logic [15:0] prod_a;
	logic [15:0] prod_b;
	logic [15:0] sum;
	logic [16:0] div_acc;

	assign prod_a = 16'(chan) * 16'(8'hFF - weight);
	assign prod_b = 16'(8'hFF - chan) * 16'(weight);
	assign sum = prod_a + prod_b;
	// divide by 255, exact for dividends up to 255*255
	assign div_acc = 17'(sum) + 17'(sum[15:8]) + 17'd1;
	assign mixed = div_acc[15:8];

endmodule

>>> hw/rtl/lmbc_core.sv
// ----------------------------------------------------------------------------
// lmbc_core
// display state: mode, tick counters, fade weight and pixel, one update per transaction
// ----------------------------------------------------------------------------
module lmbc_core #(
	parameter int unsigned TICK_COUNTER_BITS = lmbc_pkg::TICK_COUNTER_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  lmbc_pkg::req_t  item,
	input  lmbc_pkg::cfg_t  cfg,
	output lmbc_pkg::rsp_t  result
);

	localparam int unsigned CW = TICK_COUNTER_BITS;
	localparam int unsigned CMP_W =
		(TICK_COUNTER_BITS > lmbc_pkg::INTERVAL_BITS) ? TICK_COUNTER_BITS
		: lmbc_pkg::INTERVAL_BITS;

	logic [2:0]          mode_q, mode_d;
	logic [CW-1:0]       blink_q, blink_d, blink_inc;
	logic [CW-1:0]       fade_q, fade_d, fade_inc;
	logic [7:0]          weight_q, weight_d;
	lmbc_pkg::rgb_t      pix_q, pix_d, mixed;
	logic [lmbc_pkg::INTERVAL_BITS-1:0] blink_ivl;
	logic                blink_hit, fade_hit, pix_is_base;

	assign blink_inc = (blink_q == '1) ? blink_q : blink_q + CW'(1);
	assign fade_inc = (fade_q == '1) ? fade_q : fade_q + CW'(1);
	assign blink_ivl = (mode_q == lmbc_pkg::MODE_SLOW) ? cfg.slow_blink_ticks
		: cfg.fast_blink_ticks;
	assign blink_hit = CMP_W'(blink_inc) >= CMP_W'(blink_ivl);
	assign fade_hit = CMP_W'(fade_inc) >= CMP_W'(cfg.fade_step_ticks);
	assign pix_is_base = (pix_q == cfg.base);

	lmbc_mix u_mix_red (.chan(cfg.base.red), .weight(weight_q), .mixed(mixed.red));
	lmbc_mix u_mix_green (.chan(cfg.base.green), .weight(weight_q), .mixed(mixed.green));
	lmbc_mix u_mix_blue (.chan(cfg.base.blue), .weight(weight_q), .mixed(mixed.blue));

	always_comb begin
		mode_d = mode_q;
		blink_d = blink_q;
		fade_d = fade_q;
		weight_d = weight_q;
		pix_d = pix_q;
		case (item.req_type)
			lmbc_pkg::REQ_TICK: begin
				blink_d = blink_inc;
				fade_d = fade_inc;
				case (mode_q) inside
					lmbc_pkg::MODE_SLOW, lmbc_pkg::MODE_FAST: begin
						if (blink_hit) begin
							blink_d = '0;
							pix_d = pix_is_base ? '0 : cfg.base;
						end
					end
					lmbc_pkg::MODE_STEADY: begin
						pix_d = cfg.base;
					end
					lmbc_pkg::MODE_FADE: begin
						if (fade_hit) begin
							fade_d = '0;
							pix_d = mixed;
							weight_d = weight_q + 8'd1;
						end
					end
					default: begin
						pix_d = '0;
					end
				endcase
			end
			lmbc_pkg::REQ_SET_MODE: begin
				if (item.new_mode <= lmbc_pkg::MODE_FADE) begin
					mode_d = item.new_mode;
				end
				blink_d = '0;
			end
			lmbc_pkg::REQ_LINK_DROP: begin
				mode_d = lmbc_pkg::MODE_OFF;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lmbc_pkg::MODE_OFF;
			blink_q <= '0;
			fade_q <= '0;
			weight_q <= '0;
			pix_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			blink_q <= blink_d;
			fade_q <= fade_d;
			weight_q <= weight_d;
			pix_q <= pix_d;
		end
	end

	assign result.pixel_red = pix_d.red;
	assign result.pixel_green = pix_d.green;
	assign result.pixel_blue = pix_d.blue;
	assign result.active_mode = mode_d;

endmodule

>>> tb/lmbc_checker.sv
// ----------------------------------------------------------------------------
// lmbc_checker
// watches the req, rsp and cfg channels of the pixel driver, tracks the
// display mode, tick counters, fade weight and pixel color itself, and checks
// every rsp transaction field by field against the oldest predicted pixel
// ----------------------------------------------------------------------------
module lmbc_checker #(
	parameter int unsigned TICK_COUNTER_BITS = lmbc_pkg::TICK_COUNTER_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	input  logic                                 req_ready,
	input  lmbc_pkg::req_t                       req,
	input  logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	input  lmbc_pkg::rsp_t                       rsp,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [lmbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [lmbc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output int unsigned                          outstanding,
	output int unsigned                          mismatches
);

	timeunit 1ns;
	timeprecision 1ps;

	lmbc_pkg::cfg_t               settings;
	logic [2:0]                   mode_now;
	logic [TICK_COUNTER_BITS-1:0] blink_count;
	logic [TICK_COUNTER_BITS-1:0] fade_count;
	logic [7:0]                   fade_weight;
	lmbc_pkg::rgb_t               pixel_now;
	lmbc_pkg::rsp_t               expected_pixels[$];
	lmbc_pkg::rsp_t               oldest;

	initial mismatches = 0;

	function automatic logic [TICK_COUNTER_BITS-1:0] saturating_inc(
		logic [TICK_COUNTER_BITS-1:0] count);
		return (count == '1) ? count : count + TICK_COUNTER_BITS'(1);
	endfunction

	function automatic logic [7:0] blend_level(logic [7:0] level, logic [7:0] weight);
		int unsigned c;
		int unsigned w;
		c = 32'(level);
		w = 32'(weight);
		return 8'((c * (255 - w) + (255 - c) * w) / 255);
	endfunction

	function automatic lmbc_pkg::rsp_t advance_pixel(lmbc_pkg::req_t item);
		lmbc_pkg::rsp_t result;
		logic [lmbc_pkg::INTERVAL_BITS-1:0] interval;
		case (item.req_type)
			lmbc_pkg::REQ_TICK: begin
				blink_count = saturating_inc(blink_count);
				fade_count = saturating_inc(fade_count);
				case (mode_now) inside
					lmbc_pkg::MODE_SLOW, lmbc_pkg::MODE_FAST: begin
						interval = (mode_now == lmbc_pkg::MODE_SLOW)
							? settings.slow_blink_ticks : settings.fast_blink_ticks;
						if (blink_count >= interval) begin
							blink_count = '0;
							pixel_now = (pixel_now == settings.base) ? '0 : settings.base;
						end
					end
					lmbc_pkg::MODE_STEADY: pixel_now = settings.base;
					lmbc_pkg::MODE_FADE: begin
						if (fade_count >= settings.fade_step_ticks) begin
							fade_count = '0;
							pixel_now.red = blend_level(settings.base.red, fade_weight);
							pixel_now.green = blend_level(settings.base.green, fade_weight);
							pixel_now.blue = blend_level(settings.base.blue, fade_weight);
							fade_weight = fade_weight + 8'd1;
						end
					end
					default: pixel_now = '0;
				endcase
			end
			lmbc_pkg::REQ_SET_MODE: begin
				if (item.new_mode <= lmbc_pkg::MODE_FADE)
					mode_now = item.new_mode;
				blink_count = '0;
			end
			lmbc_pkg::REQ_LINK_DROP: mode_now = lmbc_pkg::MODE_OFF;
			default: ;
		endcase
		result.pixel_red = pixel_now.red;
		result.pixel_green = pixel_now.green;
		result.pixel_blue = pixel_now.blue;
		result.active_mode = mode_now;
		return result;
	endfunction

	function automatic void apply_write(logic [lmbc_pkg::CFG_INDEX_BITS-1:0] index,
		logic [lmbc_pkg::CFG_DATA_BITS-1:0] data);
		case (index)
			lmbc_pkg::REG_BASE_RED:   settings.base.red = data[7:0];
			lmbc_pkg::REG_BASE_GREEN: settings.base.green = data[7:0];
			lmbc_pkg::REG_BASE_BLUE:  settings.base.blue = data[7:0];
			lmbc_pkg::REG_SLOW_BLINK: settings.slow_blink_ticks = data;
			lmbc_pkg::REG_FAST_BLINK: settings.fast_blink_ticks = data;
			lmbc_pkg::REG_FADE_STEP:  settings.fade_step_ticks = data;
			default: ;
		endcase
	endfunction

	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.base.red = lmbc_pkg::BASE_RED_RST;
			settings.base.green = lmbc_pkg::BASE_GREEN_RST;
			settings.base.blue = lmbc_pkg::BASE_BLUE_RST;
			settings.slow_blink_ticks = lmbc_pkg::SLOW_BLINK_RST;
			settings.fast_blink_ticks = lmbc_pkg::FAST_BLINK_RST;
			settings.fade_step_ticks = lmbc_pkg::FADE_STEP_RST;
			mode_now = lmbc_pkg::MODE_OFF;
			blink_count = '0;
			fade_count = '0;
			fade_weight = '0;
			pixel_now = '0;
			expected_pixels.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (rsp_valid && rsp_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("rsp transaction with no prediction pending: %h", rsp);
					mismatches++;
				end else begin
					oldest = expected_pixels.pop_front();
					compare_field("pixel_red", oldest.pixel_red, rsp.pixel_red);
					compare_field("pixel_green", oldest.pixel_green, rsp.pixel_green);
					compare_field("pixel_blue", oldest.pixel_blue, rsp.pixel_blue);
					compare_field("active_mode", 8'(oldest.active_mode),
						8'(rsp.active_mode));
				end
			end
			if (req_valid && req_ready)
				expected_pixels.push_back(advance_pixel(req));
			outstanding <= expected_pixels.size();
		end
	end

endmodule

>>> tb/tb_led_mode_blink_crossfade.sv
// ----------------------------------------------------------------------------
// tb_led_mode_blink_crossfade
// stimulus and verdict for the pixel driver: directed requests over every
// mode, unknown mode codes, link drop and the unused request type, then
// random traffic under several register settings including the extremes,
// a long crossfade run that wraps the weight, and a long rsp hold-off
// ----------------------------------------------------------------------------
module tb_led_mode_blink_crossfade;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CLK_PERIOD = 10;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [2:0] MODE_RSVD5 = 3'd5;
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	localparam logic [lmbc_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 req_valid = 1'b0;
	logic                                 req_ready;
	lmbc_pkg::req_t                       req = '0;
	logic                                 rsp_valid;
	logic                                 rsp_ready = 1'b0;
	lmbc_pkg::rsp_t                       rsp;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [lmbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
	logic [lmbc_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;
	int unsigned                          outstanding;
	int unsigned                          mismatches;
	bit                                   tx_idle = 1'b1;
	bit                                   rx_idle = 1'b1;
	bit                                   hold_off = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	led_mode_blink_crossfade i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lmbc_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	// rsp side: random stalls, or a long hold-off when asked for
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off && hold_left == 0)
				hold_left = HOLD_CYCLES;
			if (hold_left != 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					hold_off = 1'b0;
			end else begin
				rsp_ready <= !rx_idle || ($urandom_range(99) >= 35);
			end
		end
	end

	task automatic offer_request(input logic [1:0] kind, input logic [2:0] mode);
		while (tx_idle && $urandom_range(99) < 35) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req.req_type <= kind;
		req.new_mode <= mode;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic write_register(input logic [lmbc_pkg::CFG_INDEX_BITS-1:0] index,
		input logic [lmbc_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_settings(input logic [15:0] red, input logic [15:0] green,
		input logic [15:0] blue, input logic [15:0] slow, input logic [15:0] fast,
		input logic [15:0] fade, input bit poke_unused);
		write_register(lmbc_pkg::REG_BASE_RED, red);
		write_register(lmbc_pkg::REG_BASE_GREEN, green);
		write_register(lmbc_pkg::REG_BASE_BLUE, blue);
		write_register(lmbc_pkg::REG_SLOW_BLINK, slow);
		write_register(lmbc_pkg::REG_FAST_BLINK, fast);
		write_register(lmbc_pkg::REG_FADE_STEP, fade);
		if (poke_unused)
			write_register(REG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
	endtask

	// drain all transactions, then let the pipeline go quiet
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_traffic(input int unsigned count);
		int unsigned pick;
		logic [1:0] kind;
		logic [2:0] mode;
		repeat (count) begin
			pick = $urandom_range(99);
			mode = 3'($urandom_range(7));
			if (pick < 65) begin
				kind = lmbc_pkg::REQ_TICK;
			end else if (pick < 88) begin
				kind = lmbc_pkg::REQ_SET_MODE;
				if ($urandom_range(99) < 85)
					mode = 3'($urandom_range(lmbc_pkg::MODE_FADE));
			end else if (pick < 95) begin
				kind = lmbc_pkg::REQ_LINK_DROP;
			end else begin
				kind = REQ_UNUSED;
			end
			offer_request(kind, mode);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_STEADY);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_SET_MODE, MODE_RSVD5);
		offer_request(lmbc_pkg::REQ_SET_MODE, MODE_RSVD6);
		offer_request(lmbc_pkg::REQ_SET_MODE, MODE_RSVD7);
		offer_request(REQ_UNUSED, MODE_RSVD7);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_FADE);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_LINK_DROP, lmbc_pkg::MODE_STEADY);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_SLOW);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_FAST);
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_OFF);
		drain();

		// shortest intervals, white base with noise in the upper data bits
		write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd0, 1'b0);
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_SLOW);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_FAST);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_FADE);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		offer_request(lmbc_pkg::REQ_TICK, lmbc_pkg::MODE_OFF);
		drain();

		// longest intervals, black base
		write_settings(16'hFF00, 16'hFF00, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		random_traffic(40);
		drain();

		// fade on every tick long enough to wrap the weight, under full pressure
		write_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(12)), 16'($urandom_range(6)),
			16'd0, 1'b0);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_off = 1'b1;
		offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_FADE);
		repeat (270) begin
			if ($urandom_range(99) < 95)
				offer_request(lmbc_pkg::REQ_TICK, 3'($urandom_range(7)));
			else
				offer_request(lmbc_pkg::REQ_SET_MODE, lmbc_pkg::MODE_FADE);
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		drain();

		repeat (3) begin
			write_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(12)),
				16'($urandom_range(6)), 16'($urandom_range(4)), 1'b0);
			random_traffic(40);
			drain();
		end

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
